// ----- rtl/core/dfg_pkg.sv -----
package dfg_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WAVE_W     = 2;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned GAIN_W     = 13;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned SINE_W     = 31;
  localparam int unsigned SAMPLE_W   = 18;
  localparam int unsigned LEVEL_W    = 34;
  localparam int unsigned LEVEL_FRAC = 27;

  localparam logic [GAIN_W-1:0]   OFFSET_RESET = 13'd2048;
  localparam logic [LEVEL_FRAC:0] LEVEL_FULL   = 28'h800_0000;
  localparam logic [LEVEL_FRAC:0] LEVEL_HALF   = 28'h400_0000;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598668;
  localparam logic [63:0] POLY_C5 = 64'd85569305;
  localparam logic [63:0] POLY_C7 = 64'd5026995;
  localparam logic [63:0] POLY_C9 = 64'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_SHAPE   = 3'd0,
    CFG_PHASE_STEP   = 3'd1,
    CFG_AMPLITUDE    = 3'd2,
    CFG_OFFSET_LEVEL = 3'd3,
    CFG_ENABLE       = 3'd4
  } cfg_idx_e;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2
  } wave_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MUL   = 3'd1,
    ST_PHASE = 3'd2,
    ST_ROM   = 3'd3,
    ST_LEVEL = 3'd4,
    ST_CODE  = 3'd5
  } state_e;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_shape;
    logic [STEP_W-1:0] phase_step;
    logic [GAIN_W-1:0] amplitude;
    logic [GAIN_W-1:0] offset_level;
    logic              enable;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic phase;
    logic rom;
    logic level;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic step_zero;
    logic out_busy;
  } status_t;

  // quarter-wave sine in Q30, polynomial with truncating multiplies
  function automatic logic [SINE_W-1:0] sine_quarter(input int unsigned idx,
                                                     input int unsigned qbits);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] r;
    logic [63:0] s;
    t = 64'(idx) << (30 - qbits);
    u = (t * t) >> 30;
    r = POLY_C9;
    r = POLY_C7 - ((u * r) >> 30);
    r = POLY_C5 - ((u * r) >> 30);
    r = POLY_C3 - ((u * r) >> 30);
    r = POLY_C1 - ((u * r) >> 30);
    s = (t * r) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return SINE_W'(s);
  endfunction

endpackage

// ----- rtl/core/dfg_regs.sv -----
module dfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dfg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dfg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output dfg_pkg::cfg_t                      cfg_o
);

  dfg_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dfg_pkg::cfg_idx_e'(cfg_index_i))
        dfg_pkg::CFG_WAVE_SHAPE:   cfg_d.wave_shape   = cfg_wdata_i[dfg_pkg::WAVE_W-1:0];
        dfg_pkg::CFG_PHASE_STEP:   cfg_d.phase_step   = cfg_wdata_i[dfg_pkg::STEP_W-1:0];
        dfg_pkg::CFG_AMPLITUDE:    cfg_d.amplitude    = cfg_wdata_i[dfg_pkg::GAIN_W-1:0];
        dfg_pkg::CFG_OFFSET_LEVEL: cfg_d.offset_level = cfg_wdata_i[dfg_pkg::GAIN_W-1:0];
        dfg_pkg::CFG_ENABLE:       cfg_d.enable       = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_shape   <= dfg_pkg::WAVE_SINE;
      cfg_q.phase_step   <= '0;
      cfg_q.amplitude    <= '0;
      cfg_q.offset_level <= dfg_pkg::OFFSET_RESET;
      cfg_q.enable       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/dfg_ctrl.sv -----
module dfg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dfg_pkg::status_t  status_i,
  output dfg_pkg::cmd_t     cmd_o
);

  dfg_pkg::state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dfg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && status_i.enable) begin
          cmd_o.capture = 1'b1;
          if (!status_i.step_zero) begin
            state_d = dfg_pkg::ST_MUL;
          end
        end
      end
      dfg_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = dfg_pkg::ST_PHASE;
      end
      dfg_pkg::ST_PHASE: begin
        cmd_o.phase = 1'b1;
        state_d     = dfg_pkg::ST_ROM;
      end
      dfg_pkg::ST_ROM: begin
        cmd_o.rom = 1'b1;
        state_d   = dfg_pkg::ST_LEVEL;
      end
      dfg_pkg::ST_LEVEL: begin
        cmd_o.level = 1'b1;
        state_d     = dfg_pkg::ST_CODE;
      end
      dfg_pkg::ST_CODE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = dfg_pkg::ST_IDLE;
        end
      end
      default: state_d = dfg_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/dfg_datapath.sv -----
module dfg_datapath #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned DAC_BITS        = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dfg_pkg::cfg_t                  cfg_i,
  input  dfg_pkg::cmd_t                  cmd_i,
  output dfg_pkg::status_t               status_o,
  input  logic [dfg_pkg::TIME_W-1:0]     now_us_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [DAC_BITS-1:0]            dac_code_o
);

  localparam int unsigned QBITS     = SINE_TABLE_BITS - 2;
  localparam int unsigned ROM_DEPTH = (2 ** QBITS) + 1;
  localparam int unsigned ADDR_W    = QBITS + 1;
  localparam int unsigned CLAMP_W   = dfg_pkg::LEVEL_FRAC + 1;
  localparam int unsigned CODE_W    = CLAMP_W + DAC_BITS + 1;
  localparam int unsigned TRI_W     = 15;

  logic [dfg_pkg::TIME_W-1:0]   last_time_q;
  logic [dfg_pkg::TIME_W-1:0]   elapsed_q;
  logic [dfg_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic [PHASE_BITS-1:0]        phase_q;
  logic [PHASE_BITS-1:0]        inc;
  logic [dfg_pkg::SINE_W-1:0]   sine_rom [ROM_DEPTH];
  logic [dfg_pkg::SINE_W-1:0]   rom_q;
  logic [SINE_TABLE_BITS-1:0]   tbl_idx;
  logic [1:0]                   quad;
  logic [QBITS-1:0]             q_idx;
  logic [ADDR_W-1:0]            rom_addr;
  logic [31:0]                  sine_v;
  logic signed [dfg_pkg::SAMPLE_W-1:0] sine_smp, tri_smp, sample;
  logic [TRI_W-1:0]             tri_p;
  logic signed [dfg_pkg::SAMPLE_W-1:0] tri4;
  logic signed [dfg_pkg::GAIN_W:0]     amp_s;
  logic signed [31:0]           gain_prod;
  logic signed [dfg_pkg::LEVEL_W-1:0]  level_d, level_q;
  logic [CLAMP_W-1:0]           clamped;
  logic [CODE_W-1:0]            scaled;
  logic [DAC_BITS-1:0]          code_d, dac_q;
  logic                         out_valid_d, out_valid_q;

  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
    assign sine_rom[gi] = dfg_pkg::sine_quarter(gi, QBITS);
  end

  assign prod_d = dfg_pkg::PROD_W'(elapsed_q) * dfg_pkg::PROD_W'(cfg_i.phase_step);

  if (PHASE_BITS >= 32) begin : g_inc_up
    assign inc = PHASE_BITS'(prod_q << (PHASE_BITS - 32));
  end else begin : g_inc_dn
    assign inc = PHASE_BITS'(prod_q >> (32 - PHASE_BITS));
  end

  // quadrant fold of the sine table index
  assign tbl_idx  = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad     = tbl_idx[SINE_TABLE_BITS-1 -: 2];
  assign q_idx    = tbl_idx[QBITS-1:0];
  assign rom_addr = quad[0] ? (ADDR_W'(ROM_DEPTH - 1) - {1'b0, q_idx}) : {1'b0, q_idx};

  assign sine_v   = quad[1] ? (32'h4000_0000 - 32'(rom_q)) : (32'h4000_0000 + 32'(rom_q));
  assign sine_smp = $signed({1'b0, 17'((sine_v + 32'd32768) >> 16)});

  assign tri_p = phase_q[PHASE_BITS-1 -: TRI_W];
  assign tri4  = $signed({1'b0, tri_p, 2'b00});
  assign tri_smp = phase_q[PHASE_BITS-1] ? (18'sd98304 - tri4) : (tri4 - 18'sd32768);

  always_comb begin
    case (dfg_pkg::wave_e'(cfg_i.wave_shape))
      dfg_pkg::WAVE_SINE:     sample = sine_smp;
      dfg_pkg::WAVE_SQUARE:   sample = phase_q[PHASE_BITS-1] ? -18'sd32768 : 18'sd32768;
      dfg_pkg::WAVE_TRIANGLE: sample = tri_smp;
      default:                sample = '0;
    endcase
  end

  assign amp_s     = $signed({1'b0, cfg_i.amplitude});
  assign gain_prod = 32'(amp_s) * 32'(sample);
  assign level_d   = dfg_pkg::LEVEL_W'($signed({1'b0, cfg_i.offset_level, 15'b0}))
                   + dfg_pkg::LEVEL_W'(gain_prod);

  always_comb begin
    if (level_q[dfg_pkg::LEVEL_W-1]) begin
      clamped = '0;
    end else if (level_q[dfg_pkg::LEVEL_W-2:0] > (dfg_pkg::LEVEL_W-1)'(dfg_pkg::LEVEL_FULL)) begin
      clamped = dfg_pkg::LEVEL_FULL;
    end else begin
      clamped = level_q[CLAMP_W-1:0];
    end
  end

  // level * (2^DAC_BITS - 1), rounded half up
  assign scaled = (CODE_W'(clamped) << DAC_BITS) - CODE_W'(clamped)
                + CODE_W'(dfg_pkg::LEVEL_HALF);
  assign code_d = DAC_BITS'(scaled >> dfg_pkg::LEVEL_FRAC);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.capture) begin
        last_time_q <= now_us_i;
      end
      if (cmd_i.phase) begin
        phase_q <= phase_q + inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      elapsed_q <= now_us_i - last_time_q;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.rom) begin
      rom_q <= sine_rom[rom_addr];
    end
    if (cmd_i.level) begin
      level_q <= level_d;
    end
    if (cmd_i.load_out) begin
      dac_q <= code_d;
    end
  end

  assign status_o.enable    = cfg_i.enable;
  assign status_o.step_zero = (cfg_i.phase_step == '0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign dac_code_o  = dac_q;

endmodule

// ----- rtl/core/dds_function_generator_top.sv -----
// Each accepted input is sequenced through phase multiply, phase add, sine ROM read,
// gain multiply and DAC scaling, then loaded into the output register, which waits while
// the output is stalled; no new input is taken until the sequence returns to idle.
// Disabled or zero-step inputs are taken in the idle state and give no output.
// Reset (rst_ni, async, active low): registers to defaults, phase and timestamp to zero.
module dds_function_generator_top #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned DAC_BITS        = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dfg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dfg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dfg_pkg::TIME_W-1:0]         now_us_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [DAC_BITS-1:0]                dac_code_o
);

  dfg_pkg::cfg_t    cfg;
  dfg_pkg::cmd_t    cmd;
  dfg_pkg::status_t status;

  dfg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfg_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .DAC_BITS        (DAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .now_us_i    (now_us_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .dac_code_o  (dac_code_o)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && !out_ready_i))
    else $error("result overwritten while pending");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.mul || cmd.phase || cmd.rom || cmd.level || cmd.load_out))
    else $error("datapath command while taking input");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.mul, cmd.phase, cmd.rom, cmd.level, cmd.load_out}))
    else $error("multiple datapath commands");

  a_mul_then_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul |=> cmd.phase)
    else $error("phase update did not follow multiply");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import dfg_pkg::*;

  localparam logic [1:0] WAVE_UNUSED = 2'd3;
  localparam int unsigned SEGMENTS = 20;
  localparam int unsigned SEG_ITEMS = 45;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [TIME_W-1:0]    now_us_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [11:0]          dac_code_o;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned settings_applied;
  logic [31:0] clock_us;

  class dac_code_board;
    localparam longint Q30 = 1073741824;
    localparam longint C1 = 1686629713;
    localparam longint C3 = 693598668;
    localparam longint C5 = 85569305;
    localparam longint C7 = 5026995;
    localparam longint C9 = 172272;
    localparam longint FULL = 134217728;

    logic [1:0]  shape;
    logic [31:0] step;
    logic [12:0] gain;
    logic [12:0] offset;
    logic        en;
    logic [31:0] last_us;
    logic [31:0] phase;
    logic [11:0] expected_codes[$];
    int unsigned timestamps_seen;
    int unsigned codes_checked;
    int unsigned mismatches;

    function new();
      shape = WAVE_SINE;
      step = '0;
      gain = '0;
      offset = 13'd2048;
      en = 1'b0;
      last_us = '0;
      phase = '0;
      timestamps_seen = 0;
      codes_checked = 0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_WAVE_SHAPE:   shape = val[1:0];
        CFG_PHASE_STEP:   step = val;
        CFG_AMPLITUDE:    gain = val[12:0];
        CFG_OFFSET_LEVEL: offset = val[12:0];
        CFG_ENABLE:       en = val[0];
        default: ;
      endcase
    endfunction

    // Q1.15 sample, +32768 is +1.0
    function longint wave_value(logic [31:0] ph);
      longint t;
      longint u;
      longint r;
      longint s;
      longint v;
      case (shape)
        WAVE_SINE: begin
          t = longint'(ph[29:22]) <<< 22;
          if (ph[30]) t = Q30 - t;
          u = (t * t) / Q30;
          r = C7 - (u * C9) / Q30;
          r = C5 - (u * r) / Q30;
          r = C3 - (u * r) / Q30;
          r = C1 - (u * r) / Q30;
          s = (t * r) / Q30;
          if (s > Q30) s = Q30;
          if (s < 0) s = 0;
          v = ph[31] ? Q30 - s : Q30 + s;
          return (v + 32768) / 65536;
        end
        WAVE_SQUARE: return ph[31] ? -32768 : 32768;
        WAVE_TRIANGLE: begin
          return ph[31] ? 98304 - 4 * longint'(ph[31:17]) : 4 * longint'(ph[31:17]) - 32768;
        end
        default: return 0;
      endcase
    endfunction

    function void note_timestamp(logic [31:0] now);
      logic [31:0] elapsed;
      logic [63:0] prod;
      longint lvl;
      timestamps_seen++;
      if (!en) return;
      elapsed = now - last_us;
      last_us = now;
      if (step == '0) return;
      prod = 64'(elapsed) * 64'(step);
      phase = phase + prod[31:0];
      lvl = (longint'(offset) <<< 15) + longint'(gain) * wave_value(phase);
      if (lvl < 0) lvl = 0;
      if (lvl > FULL) lvl = FULL;
      lvl = (lvl * 4095 + FULL / 2) >>> 27;
      expected_codes.push_back(lvl[11:0]);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_code(logic [11:0] code);
      logic [11:0] want;
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("dac_code %0d with no sample pending", code));
        return;
      end
      want = expected_codes.pop_front();
      codes_checked++;
      if (code !== want) begin
        report_mismatch($sformatf("dac_code %0d, predicted %0d", code, want));
      end
    endtask
  endclass

  dac_code_board codes;

  dds_function_generator_top uut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // output side: check each transfer, then pick next ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      codes.check_code(dac_code_o);
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    codes.set_reg(idx, val);
  endtask

  task automatic send_timestamp(input logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_us_i <= now;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    codes.note_timestamp(now);
  endtask

  // block idle: nothing pending, plus room for a no-output item in flight
  task automatic drain();
    in_valid_i <= 1'b0;
    while (codes.expected_codes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] next_stamp();
    case ($urandom_range(0, 9))
      0: clock_us = $urandom;
      1: clock_us = clock_us + $urandom;
      2, 3, 4: clock_us = clock_us + $urandom_range(0, 1 << 20);
      default: clock_us = clock_us + $urandom_range(0, 2000);
    endcase
    return clock_us;
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(4097, 8191);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  task automatic random_settings();
    logic [1:0]  shape;
    logic [31:0] step;
    case ($urandom_range(0, 9))
      0, 1, 2: shape = WAVE_SINE;
      3, 4, 5: shape = WAVE_SQUARE;
      6, 7, 8: shape = WAVE_TRIANGLE;
      default: shape = WAVE_UNUSED;
    endcase
    case ($urandom_range(0, 9))
      0: step = 32'd0;
      1: step = 32'hFFFF_FFFF;
      2, 3, 4, 5: step = $urandom_range(1, 1 << 20);
      default: step = $urandom;
    endcase
    write_reg(CFG_WAVE_SHAPE, {30'd0, shape});
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_AMPLITUDE, pick_level());
    write_reg(CFG_OFFSET_LEVEL, pick_level());
    write_reg(CFG_ENABLE, {31'd0, ($urandom_range(0, 7) != 0)});
    settings_applied++;
  endtask

  initial begin
    codes = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_WAVE_SHAPE;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    now_us_i = '0;
    out_ready_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    settings_applied = 0;
    clock_us = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset: ignored, no time tracking
    send_timestamp(32'h0000_1234);
    send_timestamp(32'hFFFF_FFFF);
    drain();
    write_reg(CFG_ENABLE, 1);
    // zero step: timestamp kept, no sample
    send_timestamp(32'd100);
    drain();
    write_reg(CFG_PHASE_STEP, 32'h1000_0000);
    write_reg(CFG_AMPLITUDE, 4096);
    for (int i = 1; i <= 6; i++) send_timestamp(100 + 3 * i);
    drain();
    write_reg(CFG_WAVE_SHAPE, {30'd0, WAVE_SQUARE});
    write_reg(CFG_AMPLITUDE, 8191);
    write_reg(CFG_OFFSET_LEVEL, 0);
    send_timestamp(32'hFFFF_FFF0);
    send_timestamp(32'h0000_0010);
    send_timestamp(32'h0000_0010);
    drain();
    write_reg(CFG_WAVE_SHAPE, {30'd0, WAVE_TRIANGLE});
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_AMPLITUDE, 4096);
    for (int i = 1; i <= 4; i++) send_timestamp(32'h0000_0010 + 32'h1000_0000 * i);
    drain();
    write_reg(CFG_WAVE_SHAPE, {30'd0, WAVE_UNUSED});
    write_reg(CFG_OFFSET_LEVEL, 8191);
    send_timestamp(32'h8000_0000);
    drain();
    write_reg(CFG_WAVE_SHAPE, {30'd0, WAVE_SINE});
    write_reg(CFG_AMPLITUDE, 0);
    write_reg(CFG_OFFSET_LEVEL, 4096);
    send_timestamp(32'h8000_0001);
    drain();
    write_reg(CFG_ENABLE, 0);
    send_timestamp(32'h9000_0000);
    drain();
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_AMPLITUDE, 4096);
    write_reg(CFG_OFFSET_LEVEL, 2048);
    send_timestamp(32'h8000_0101);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 71;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 71;
        end
        default: begin
          idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      random_settings();
      repeat (SEG_ITEMS) send_timestamp(next_stamp());
      drain();
    end

    $display("Run covered %0d timestamp transfers and %0d checked DAC codes over %0d random settings,",
             codes.timestamps_seen, codes.codes_checked, settings_applied);
    $display("all wave shapes plus the unused code, wrapped time, zero step, disable and clamping.");
    if (codes.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dfg_pkg.sv
rtl/core/dfg_regs.sv
rtl/core/dfg_ctrl.sv
rtl/core/dfg_datapath.sv
rtl/core/dds_function_generator_top.sv
tb/tb_top.sv
